// ===== src/adbs_pkg.sv =====
`timescale 1ns / 1ps
package adbs_pkg;

   localparam int SAMPLE_W = 12;
   localparam int FRAC_W = 8;
   localparam int SMOOTH_W = SAMPLE_W + FRAC_W;
   localparam int LEVEL_W = 8;
   localparam int TIME_W = 32;
   localparam int LEVELS = 1 << LEVEL_W;
   localparam int LEVEL_BIT_W = $clog2(LEVEL_W);

   localparam int CURVE_ENTRIES = 1024;
   localparam int CURVE_TOP = CURVE_ENTRIES - 1;
   localparam int CURVE_BITS = $clog2(CURVE_ENTRIES);
   localparam int PROD_W = SMOOTH_W + CURVE_BITS;
   localparam int NUM_W = PROD_W - FRAC_W;
   localparam int DIV_CNT_W = $clog2(CURVE_BITS + 1);
   localparam logic [CURVE_BITS-1:0] IDX_TOP = CURVE_BITS'(CURVE_TOP);

   localparam int BOOST_MS = 2000;
   localparam logic [TIME_W-1:0] BOOST_WINDOW = TIME_W'(BOOST_MS);

   // curve y = 255 * x^(12/5), compared as (2y - 1)/510 against x^(12/5)
   localparam int CURVE_POW_NUM = 12;
   localparam int CURVE_POW_DEN = 5;
   localparam int CURVE_HALF_SCALE = 510;
   localparam int BIG_W = 200;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN_ON = LEVEL_W'(1);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_HOME = 1'b1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ALLOW_OFF = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BOOST_LEVEL = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_AUTO_MODE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MANUAL_LEVEL = 3'd4;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = '1;
   localparam logic [LEVEL_W-1:0] BOOST_LEVEL_RESET = '1;
   localparam logic [LEVEL_W-1:0] MANUAL_LEVEL_RESET = LEVEL_W'(128);

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] light_sample;
      logic [TIME_W-1:0]   now_ms;
      logic                alarm_on;
      logic                on_home_screen;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  brightness;
      logic [SAMPLE_W-1:0] last_raw;
      logic                boosting;
   } rsp_word_type;

   function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base, input int times);
      logic [BIG_W-1:0] acc;
      acc = BIG_W'(1);
      for (int i = 0; i < times; i++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

   function automatic bit curve_reaches(input int idx, input int y);
      logic [BIG_W-1:0] lhs;
      logic [BIG_W-1:0] rhs;
      lhs = big_pow(BIG_W'(idx), CURVE_POW_NUM) * big_pow(BIG_W'(CURVE_HALF_SCALE), CURVE_POW_DEN);
      rhs = big_pow(BIG_W'(2 * y - 1), CURVE_POW_DEN) * big_pow(BIG_W'(CURVE_TOP), CURVE_POW_NUM);
      return lhs >= rhs;
   endfunction

   // smallest curve index whose rounded value reaches y
   function automatic logic [CURVE_BITS-1:0] curve_threshold(input int y);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = CURVE_TOP;
      if (y == 0) begin
         return '0;
      end
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (curve_reaches(mid, y)) begin
            hi = mid;
         end else begin
            lo = mid + 1;
         end
      end
      return CURVE_BITS'(lo);
   endfunction

endpackage

// ===== src/adbs_divider.sv =====
`timescale 1ns / 1ps
module adbs_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [adbs_pkg::NUM_W-1:0]          num,
   input  logic [adbs_pkg::SAMPLE_W-1:0]       divisor,
   output logic                                done,
   output logic [adbs_pkg::CURVE_BITS-1:0]     quot
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [adbs_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [adbs_pkg::SAMPLE_W-1:0]       rem_ff, rem_in;
   logic [adbs_pkg::SAMPLE_W-1:0]       div_ff, div_in;
   logic [adbs_pkg::CURVE_BITS-1:0]     low_ff, low_in;
   logic [adbs_pkg::CURVE_BITS-1:0]     quot_ff, quot_in;
   logic [adbs_pkg::SAMPLE_W:0]         trial;
   logic [adbs_pkg::SAMPLE_W:0]         diff;
   logic                                ge;
   logic [adbs_pkg::NUM_W-1:0]          limit;

   assign limit = {divisor, {adbs_pkg::CURVE_BITS{1'b0}}};
   assign trial = {rem_ff, low_ff[adbs_pkg::CURVE_BITS-1]};
   assign diff = trial - {1'b0, div_ff};
   assign ge = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      low_in = low_ff;
      quot_in = quot_ff;
      if (start) begin
         div_in = divisor;
         if (divisor == '0) begin
            quot_in = (num != '0) ? adbs_pkg::IDX_TOP : '0;
            done_in = 1'b1;
         end else if (num >= limit) begin
            quot_in = adbs_pkg::IDX_TOP;
            done_in = 1'b1;
         end else begin
            rem_in = num[adbs_pkg::NUM_W-1:adbs_pkg::CURVE_BITS];
            low_in = num[adbs_pkg::CURVE_BITS-1:0];
            quot_in = '0;
            cnt_in = adbs_pkg::DIV_CNT_W'(adbs_pkg::CURVE_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[adbs_pkg::SAMPLE_W-1:0] : trial[adbs_pkg::SAMPLE_W-1:0];
         quot_in = {quot_ff[adbs_pkg::CURVE_BITS-2:0], ge};
         low_in = {low_ff[adbs_pkg::CURVE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - adbs_pkg::DIV_CNT_W'(1);
         if (cnt_ff == adbs_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = (quot_ff > adbs_pkg::IDX_TOP) ? adbs_pkg::IDX_TOP : quot_ff;

endmodule

// ===== src/adbs_curve.sv =====
`timescale 1ns / 1ps
module adbs_curve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [adbs_pkg::CURVE_BITS-1:0]     idx,
   output logic                                done,
   output logic [adbs_pkg::LEVEL_W-1:0]        level
);

   logic [adbs_pkg::CURVE_BITS-1:0]     thr [adbs_pkg::LEVELS];
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [adbs_pkg::LEVEL_BIT_W-1:0]    bit_ff, bit_in;
   logic [adbs_pkg::LEVEL_W-1:0]        val_ff, val_in;
   logic [adbs_pkg::CURVE_BITS-1:0]     idx_ff, idx_in;
   logic [adbs_pkg::LEVEL_W-1:0]        trial;
   logic                                take;

   // first curve index that reaches each level
   for (genvar g = 0; g < adbs_pkg::LEVELS; g++) begin : g_thr
      localparam logic [adbs_pkg::CURVE_BITS-1:0] TH = adbs_pkg::curve_threshold(g);
      assign thr[g] = TH;
   end

   assign trial = val_ff | (adbs_pkg::LEVEL_W'(1) << bit_ff);
   assign take = thr[trial] <= idx_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in = bit_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      if (start) begin
         idx_in = idx;
         val_in = '0;
         bit_in = adbs_pkg::LEVEL_BIT_W'(adbs_pkg::LEVEL_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (take) begin
            val_in = trial;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - adbs_pkg::LEVEL_BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      idx_ff <= idx_in;
   end

   assign done = done_ff;
   assign level = val_ff;

endmodule

// ===== src/ambient_display_brightness_select_unit.sv =====
`timescale 1ns / 1ps
// Picks a display brightness for each light-sensor word. A sample word updates an exponential
// average of the light level (gain 1/4, 12.8 fixed point, first sample loads it) and returns
// one result word; a home-event word only records its time stamp and returns nothing. Priority:
// alarm gives 255, a non-home screen or the 2000 ms window after a home event gives the boost
// level, otherwise auto mode follows a round(255*x^2.4) curve of the smoothed level over full
// scale and manual mode gives the manual level; every level but the alarm's is held at 1 or
// above unless allow_off is set. A sample word passes from acceptance to a valid result through
// a load step, a bit-serial divider producing the 10 curve-index bits one bit per cycle, a
// hand-off step, an 8-step successive-approximation search over the curve thresholds, a hand-off
// step and the output step. When full scale is zero or the level saturates the curve index the
// divider finishes at once. One sample is in work at a time and the next word is taken the cycle
// after the result is loaded, and the result is loaded only once rsp_ready lets the output take
// it; the result register lets the next word in while a result waits.
module ambient_display_brightness_select_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  adbs_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output adbs_pkg::rsp_word_type                 rsp_word,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [adbs_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [adbs_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [adbs_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_CURVE = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [adbs_pkg::SAMPLE_W-1:0]       full_scale_ff;
   logic                                allow_off_ff;
   logic [adbs_pkg::LEVEL_W-1:0]        boost_level_ff;
   logic                                auto_mode_ff;
   logic [adbs_pkg::LEVEL_W-1:0]        manual_level_ff;

   logic [adbs_pkg::SMOOTH_W-1:0]       smoothed_ff, smoothed_in;
   logic                                have_ff, have_in;
   logic [adbs_pkg::TIME_W-1:0]         home_time_ff, home_time_in;
   logic [adbs_pkg::SAMPLE_W-1:0]       raw_ff, raw_in;
   logic                                alarm_ff, alarm_in;
   logic                                home_ff, home_in;
   logic                                boost_ff, boost_in;
   logic [adbs_pkg::LEVEL_W-1:0]        curve_ff, curve_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   adbs_pkg::rsp_word_type              rsp_word_ff, rsp_word_in;

   logic                                cfg_write;
   logic [adbs_pkg::REG_IDX_W-1:0]      cfg_idx;
   logic                                req_take;
   logic                                out_load;
   logic [adbs_pkg::SMOOTH_W+1:0]       blend;
   logic [adbs_pkg::TIME_W-1:0]         elapsed;
   logic                                boost_now;
   logic [adbs_pkg::PROD_W-1:0]         prod;
   logic                                div_start;
   logic                                div_done;
   logic [adbs_pkg::CURVE_BITS-1:0]     div_quot;
   logic                                curve_start;
   logic                                curve_done;
   logic [adbs_pkg::LEVEL_W-1:0]        curve_level;
   logic [adbs_pkg::LEVEL_W-1:0]        pick;
   logic [adbs_pkg::LEVEL_W-1:0]        floored;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[adbs_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= adbs_pkg::FULL_SCALE_RESET;
         allow_off_ff <= 1'b0;
         boost_level_ff <= adbs_pkg::BOOST_LEVEL_RESET;
         auto_mode_ff <= 1'b1;
         manual_level_ff <= adbs_pkg::MANUAL_LEVEL_RESET;
      end else if (cfg_write) begin
         unique case (cfg_idx)
            adbs_pkg::REG_FULL_SCALE: full_scale_ff <= pwdata[adbs_pkg::SAMPLE_W-1:0];
            adbs_pkg::REG_ALLOW_OFF: allow_off_ff <= pwdata[0];
            adbs_pkg::REG_BOOST_LEVEL: boost_level_ff <= pwdata[adbs_pkg::LEVEL_W-1:0];
            adbs_pkg::REG_AUTO_MODE: auto_mode_ff <= pwdata[0];
            adbs_pkg::REG_MANUAL_LEVEL: manual_level_ff <= pwdata[adbs_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         adbs_pkg::REG_FULL_SCALE: prdata = adbs_pkg::CSR_DATA_W'(full_scale_ff);
         adbs_pkg::REG_ALLOW_OFF: prdata = adbs_pkg::CSR_DATA_W'(allow_off_ff);
         adbs_pkg::REG_BOOST_LEVEL: prdata = adbs_pkg::CSR_DATA_W'(boost_level_ff);
         adbs_pkg::REG_AUTO_MODE: prdata = adbs_pkg::CSR_DATA_W'(auto_mode_ff);
         adbs_pkg::REG_MANUAL_LEVEL: prdata = adbs_pkg::CSR_DATA_W'(manual_level_ff);
         default: prdata = '0;
      endcase
   end

   assign req_ready = state_ff == S_IDLE;
   assign req_take = req_valid && req_ready;

   // (3 s + sample * 256 + 2) / 4
   assign blend = {2'b00, smoothed_ff} + {1'b0, smoothed_ff, 1'b0}
                + {2'b00, req_word.light_sample, {adbs_pkg::FRAC_W{1'b0}}}
                + (adbs_pkg::SMOOTH_W + 2)'(2);
   assign elapsed = req_word.now_ms - home_time_ff;
   assign boost_now = (home_time_ff != '0) && (elapsed <= adbs_pkg::BOOST_WINDOW);

   assign prod = adbs_pkg::PROD_W'(adbs_pkg::CURVE_TOP) * adbs_pkg::PROD_W'(smoothed_ff);

   adbs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (prod[adbs_pkg::PROD_W-1:adbs_pkg::FRAC_W]),
      .divisor (full_scale_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

   adbs_curve u_curve (
      .clock (clock),
      .reset (reset),
      .start (curve_start),
      .idx   (div_quot),
      .done  (curve_done),
      .level (curve_level)
   );

   always_comb begin
      priority if (alarm_ff) begin
         pick = adbs_pkg::LEVEL_MAX;
      end else if (!home_ff || boost_ff) begin
         pick = boost_level_ff;
      end else if (auto_mode_ff) begin
         pick = curve_ff;
      end else begin
         pick = manual_level_ff;
      end
   end

   assign floored = (!alarm_ff && !allow_off_ff && pick == '0) ? adbs_pkg::LEVEL_MIN_ON : pick;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      smoothed_in = smoothed_ff;
      have_in = have_ff;
      home_time_in = home_time_ff;
      raw_in = raw_ff;
      alarm_in = alarm_ff;
      home_in = home_ff;
      boost_in = boost_ff;
      curve_in = curve_ff;
      div_start = 1'b0;
      curve_start = 1'b0;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_word.cmd == adbs_pkg::CMD_HOME) begin
                  home_time_in = req_word.now_ms;
               end else begin
                  raw_in = req_word.light_sample;
                  have_in = 1'b1;
                  smoothed_in = have_ff ? blend[adbs_pkg::SMOOTH_W+1:2]
                              : {req_word.light_sample, {adbs_pkg::FRAC_W{1'b0}}};
                  alarm_in = req_word.alarm_on;
                  home_in = req_word.on_home_screen;
                  boost_in = boost_now;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               curve_start = 1'b1;
               state_in = S_CURVE;
            end
         end
         S_CURVE: begin
            if (curve_done) begin
               curve_in = curve_level;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_word_in.brightness = floored;
               rsp_word_in.last_raw = raw_ff;
               rsp_word_in.boosting = boost_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         smoothed_ff <= '0;
         have_ff <= 1'b0;
         home_time_ff <= '0;
         raw_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         smoothed_ff <= smoothed_in;
         have_ff <= have_in;
         home_time_ff <= home_time_in;
         raw_ff <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alarm_ff <= alarm_in;
      home_ff <= home_in;
      boost_ff <= boost_in;
      curve_ff <= curve_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_curve_done_in_curve: assert property (@(posedge clock) disable iff (reset)
      curve_done |-> state_ff == S_CURVE)
      else $error("curve search finished outside the search step");

   a_home_no_work: assert property (@(posedge clock) disable iff (reset)
      req_take && req_word.cmd == adbs_pkg::CMD_HOME |=> state_ff == S_IDLE && $stable(smoothed_ff))
      else $error("home event started sample work");

   a_alarm_full: assert property (@(posedge clock) disable iff (reset)
      out_load && alarm_ff |=> rsp_valid && rsp_word.brightness == adbs_pkg::LEVEL_MAX)
      else $error("alarm word without full brightness");

endmodule
